@@ rtl/core/eab_pkg.sv @@
// Shared types, constants and table lookups for the elliptic arc to Bezier block.
// Used by every module under rtl/core; no dependencies of its own.
`default_nettype none
package eab_pkg;

  localparam int MAX_PARTS    = 5;
  localparam int CORDIC_STEPS = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam int ANG_W  = 24;
  localparam int TRIG_W = 34;
  localparam int UNIT_W = 20;
  localparam int VEC_W  = 44;
  localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
  localparam int PART_W = $clog2(MAX_PARTS + 1);
  localparam int TAB_W  = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [ANG_W-1:0] A_PI      = 205887;
  localparam logic signed [ANG_W-1:0] A_HALF_PI = 102944;
  localparam logic signed [ANG_W-1:0] A_TWO_PI  = 411775;

  localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 652032874;
  localparam logic signed [TRIG_W-1:0] ONE_Q30  = 1073741824;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCKWISE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPATIBLE = 2'd1;

  typedef struct packed {
    logic signed [ANG_W-1:0] ang_start;
    logic signed [ANG_W-1:0] ang_end;
    logic signed [15:0]      x0;
    logic signed [15:0]      x1;
    logic signed [15:0]      y0;
    logic signed [15:0]      y1;
    logic                    cw;
  } arc_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [TAB_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      5'd0:    r = 51472;
      5'd1:    r = 30385;
      5'd2:    r = 16055;
      5'd3:    r = 8150;
      5'd4:    r = 4091;
      5'd5:    r = 2047;
      5'd6:    r = 1024;
      5'd7:    r = 512;
      5'd8:    r = 256;
      5'd9:    r = 128;
      5'd10:   r = 64;
      5'd11:   r = 32;
      5'd12:   r = 16;
      5'd13:   r = 8;
      5'd14:   r = 4;
      5'd15:   r = 2;
      5'd16:   r = 1;
      default: r = 0;
    endcase
    return r;
  endfunction

  // First quarter boundary past the start angle in the arc direction
  function automatic logic signed [ANG_W-1:0] first_boundary(
      input logic signed [ANG_W-1:0] a, input logic cw);
    logic signed [ANG_W-1:0] r;
    int k;
    r = '0;
    if (cw) begin
      for (k = -5; k <= 5; k++) begin
        if (k * A_HALF_PI <= a) r = ANG_W'((k + 1) * A_HALF_PI);
      end
    end else begin
      for (k = 5; k >= -5; k--) begin
        if (k * A_HALF_PI >= a) r = ANG_W'((k - 1) * A_HALF_PI);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/eab_sincos.sv @@
// Rotation CORDIC: cosine and sine of a Q16 angle, results in Q30.
// Depends on eab_pkg.
`default_nettype none
module eab_sincos (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [eab_pkg::ANG_W-1:0]  angle,
  output logic                              done,
  output logic signed [eab_pkg::TRIG_W-1:0] cos_q30,
  output logic signed [eab_pkg::TRIG_W-1:0] sin_q30
);
  import eab_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RED, S_ITER} sstate_t;

  localparam logic [STEP_W-1:0] STEP_END = STEP_W'(CORDIC_STEPS);

  sstate_t                  state;
  logic signed [ANG_W-1:0]  ang;
  logic signed [TRIG_W-1:0] x;
  logic signed [TRIG_W-1:0] y;
  logic                     neg;
  logic [STEP_W-1:0]        step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_ITER) && (step == STEP_END);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ang   <= angle;
            neg   <= 1'b0;
            state <= S_RED;
          end
        end
        S_RED: begin
          if (ang > A_PI) begin
            ang <= ang - A_TWO_PI;
          end else if (ang < -A_PI) begin
            ang <= ang + A_TWO_PI;
          end else begin
            if (ang > A_HALF_PI) begin
              ang <= ang - A_PI;
              neg <= 1'b1;
            end else if (ang < -A_HALF_PI) begin
              ang <= ang + A_PI;
              neg <= 1'b1;
            end
            x     <= GAIN_Q30;
            y     <= '0;
            step  <= '0;
            state <= S_ITER;
          end
        end
        S_ITER: begin
          if (step == STEP_END) begin
            cos_q30 <= neg ? -x : x;
            sin_q30 <= neg ? -y : y;
            state   <= S_IDLE;
          end else begin
            if (ang >= 0) begin
              x   <= x - (y >>> step);
              y   <= y + (x >>> step);
              ang <= ang - atan_entry(TAB_W'(step));
            end else begin
              x   <= x + (y >>> step);
              y   <= y - (x >>> step);
              ang <= ang + atan_entry(TAB_W'(step));
            end
            step <= step + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/eab_front.sv @@
// Front end: takes an arc transaction, sorts the box, finds both angles by
// vectoring CORDIC, wraps the end angle and queues the arc. Depends on eab_pkg.
`default_nettype none
module eab_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] box_x1,
  input  logic signed [15:0] box_y1,
  input  logic signed [15:0] box_x2,
  input  logic signed [15:0] box_y2,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic               clockwise,
  input  logic               compatible_mode,
  output logic               q_push,
  output eab_pkg::arc_t      q_data,
  input  logic               q_full
);
  import eab_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MULY, F_MULX, F_PRE, F_NORM, F_ITER, F_WRAP, F_PUSH}
    fstate_t;

  localparam logic [STEP_W-1:0] STEP_END = STEP_W'(CORDIC_STEPS);
  localparam logic signed [VEC_W-1:0] LIM_COARSE = {{(VEC_W-33){1'b0}}, 1'b1, 32'b0};
  localparam logic signed [VEC_W-1:0] LIM_FINE   = {{(VEC_W-41){1'b0}}, 1'b1, 40'b0};

  fstate_t                 state;
  logic signed [15:0]      x0, x1, y0, y1, sx, sy, ex, ey;
  logic                    cw, compat, sel;
  logic signed [VEC_W-1:0] vx, vy;
  logic signed [ANG_W-1:0] z, ang_s;
  logic [STEP_W-1:0]       step;
  arc_t                    arc;

  logic signed [17:0]      w, h;
  logic signed [15:0]      px, py;
  logic signed [18:0]      dxn, dyn;
  logic signed [36:0]      prod_x, prod_y;
  logic signed [VEC_W-1:0] ay, m;
  logic                    in_take;

  assign w      = 18'(x1) - 18'(x0);
  assign h      = 18'(y1) - 18'(y0);
  assign px     = sel ? ex : sx;
  assign py     = sel ? ey : sy;
  assign dxn    = 19'(px) + 19'(px) - 19'(x0) - 19'(x0) - 19'(w);
  assign dyn    = 19'(py) + 19'(py) - 19'(y0) - 19'(y0) - 19'(h);
  assign prod_x = 37'(dxn) * 37'(h);
  assign prod_y = 37'(dyn) * 37'(w);
  assign ay     = (vy < 0) ? -vy : vy;
  assign m      = (vx > ay) ? vx : ay;

  assign in_stall = (state != F_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign q_push   = (state == F_PUSH) && !q_full;
  assign q_data   = arc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_take && box_x1 != box_x2 && box_y1 != box_y2) begin
            x0     <= (box_x1 > box_x2) ? box_x2 : box_x1;
            x1     <= (box_x1 > box_x2) ? box_x1 : box_x2;
            y0     <= (box_y1 > box_y2) ? box_y2 : box_y1;
            y1     <= (box_y1 > box_y2) ? box_y1 : box_y2;
            sx     <= start_x;
            sy     <= start_y;
            ex     <= end_x;
            ey     <= end_y;
            cw     <= clockwise;
            compat <= compatible_mode;
            sel    <= 1'b0;
            state  <= F_MULY;
          end
        end
        F_MULY: begin
          vy    <= VEC_W'(prod_y);
          state <= F_MULX;
        end
        F_MULX: begin
          vx    <= VEC_W'(prod_x);
          state <= F_PRE;
        end
        F_PRE: begin
          if (vx == 0 && vy == 0) begin
            z     <= '0;
            step  <= STEP_END;
            state <= F_ITER;
          end else begin
            if (vx < 0) begin
              z  <= (vy >= 0) ? A_PI : -A_PI;
              vx <= -vx;
              vy <= -vy;
            end else begin
              z <= '0;
            end
            state <= F_NORM;
          end
        end
        F_NORM: begin
          if (m < LIM_COARSE) begin
            vx <= vx <<< 8;
            vy <= vy <<< 8;
          end else if (m < LIM_FINE) begin
            vx <= vx <<< 1;
            vy <= vy <<< 1;
          end else begin
            step  <= '0;
            state <= F_ITER;
          end
        end
        F_ITER: begin
          if (step == STEP_END) begin
            if (!sel) begin
              ang_s <= z;
              sel   <= 1'b1;
              state <= F_MULY;
            end else begin
              state <= F_WRAP;
            end
          end else begin
            if (vy > 0) begin
              vx <= vx + (vy >>> step);
              vy <= vy - (vx >>> step);
              z  <= z + atan_entry(TAB_W'(step));
            end else begin
              vx <= vx - (vy >>> step);
              vy <= vy + (vx >>> step);
              z  <= z - atan_entry(TAB_W'(step));
            end
            step <= step + 1'b1;
          end
        end
        F_WRAP: begin
          arc.ang_start <= ang_s;
          if (cw) begin
            arc.ang_end <= (z <= ang_s) ? z + A_TWO_PI : z;
          end else begin
            arc.ang_end <= (z >= ang_s) ? z - A_TWO_PI : z;
          end
          arc.x0 <= x0;
          arc.y0 <= y0;
          arc.x1 <= compat ? x1 - 16'sd1 : x1;
          arc.y1 <= compat ? y1 - 16'sd1 : y1;
          arc.cw <= cw;
          state  <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/eab_queue.sv @@
// Short queue of classified arcs between the front and back ends.
// Depends on eab_pkg.
`default_nettype none
module eab_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  eab_pkg::arc_t wdata,
  output logic          full,
  input  logic          pop,
  output eab_pkg::arc_t rdata,
  output logic          empty
);
  import eab_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  arc_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign rdata = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on write");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
      (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("queue count did not drop on read");

endmodule
`default_nettype wire

@@ rtl/core/eab_back.sv @@
// Back end: splits a queued arc at quarter turns, builds each cubic Bezier with
// the shared CORDIC and a restoring divider, scales and emits the points.
// Depends on eab_pkg and eab_sincos.
`default_nettype none
module eab_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  eab_pkg::arc_t      q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] point_x,
  output logic signed [15:0] point_y,
  output logic               point_kind,
  output logic               last_point
);
  import eab_pkg::*;

  typedef enum logic [3:0] {B_IDLE, B_QSEL, B_S0, B_SH, B_DCHK, B_DIV, B_S3,
                            B_M0, B_M1, B_M2, B_M3, B_EMUL, B_EOUT} bstate_t;

  localparam int NUM_W = 52;
  localparam int DEN_W = 36;
  localparam int REM_W = 54;
  localparam int A_W   = 18;
  localparam int QBITS = 17;
  localparam int DSTEP_W = $clog2(QBITS);
  localparam int PROD_W = A_W + UNIT_W;
  localparam int SC_W = 42;
  localparam logic [DSTEP_W-1:0] DSTEP_TOP = DSTEP_W'(QBITS - 1);
  localparam logic [QBITS-1:0] A_MAX = 17'd65536;
  localparam logic signed [TRIG_W-1:0] Q30_RND = 8192;
  localparam logic signed [PROD_W-1:0] MUL_RND = 32768;
  localparam logic signed [20:0] UNIT_OFS = 65536;
  localparam logic signed [SC_W-1:0] SC_RND = 65536;

  function automatic logic signed [UNIT_W-1:0] q30_to_q16(
      input logic signed [TRIG_W-1:0] v);
    return UNIT_W'((v + Q30_RND) >>> 14);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [SC_W-1:0] v);
    logic signed [24:0] t;
    t = 25'(v >>> 17);
    if (t > 25'sd32767) return 16'sh7fff;
    if (t < -25'sd32768) return 16'sh8000;
    return 16'(t);
  endfunction

  bstate_t                  state;
  arc_t                     arc;
  logic                     first, last;
  logic [PART_W-1:0]        parts;
  logic signed [ANG_W-1:0]  qe, half;
  logic signed [UNIT_W-1:0] xs [4];
  logic signed [UNIT_W-1:0] ys [4];
  logic signed [A_W-1:0]    a;
  logic signed [NUM_W-1:0]  num;
  logic signed [DEN_W-1:0]  den;
  logic signed [REM_W-1:0]  rem;
  logic [QBITS-1:0]         quo;
  logic [DSTEP_W-1:0]       dstep;
  logic [1:0]               idx;
  logic signed [SC_W-1:0]   px_raw, py_raw;
  logic                     sc_start;
  logic signed [ANG_W-1:0]  sc_angle;
  logic                     sc_done;
  logic signed [TRIG_W-1:0] sc_cos, sc_sin;

  logic [PART_W-1:0]        parts_n;
  logic signed [ANG_W-1:0]  qs_n, qe_n, qe_fin, half_n, half_abs;
  logic signed [ANG_W:0]    diff;
  logic                     end_now;
  logic signed [REM_W-1:0]  den_sh;
  logic                     rem_ge;
  logic [QBITS-1:0]         quo_fin, quo_cl;
  logic signed [A_W-1:0]    a_div;
  logic signed [UNIT_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [UNIT_W-1:0] prod_r;
  logic signed [16:0]       dx, dy;
  logic signed [20:0]       nx, ny;
  logic                     out_free;
  logic                     emit;
  logic                     div_skip;
  logic                     sc_go;

  eab_sincos u_sincos (
    .clk     (clk),
    .rst     (rst),
    .start   (sc_start),
    .angle   (sc_angle),
    .done    (sc_done),
    .cos_q30 (sc_cos),
    .sin_q30 (sc_sin)
  );

  assign parts_n = parts + 1'b1;
  assign qs_n    = first ? arc.ang_start : qe;
  assign qe_n    = first ? first_boundary(arc.ang_start, arc.cw)
                         : (arc.cw ? qe + A_HALF_PI : qe - A_HALF_PI);
  assign end_now = (arc.cw && arc.ang_end < qe_n) || (!arc.cw && arc.ang_end > qe_n)
                   || (parts_n >= PART_W'(MAX_PARTS));
  assign qe_fin  = end_now ? arc.ang_end : qe_n;
  assign diff    = (ANG_W+1)'(qe_fin) - (ANG_W+1)'(qs_n);
  assign half_n  = diff[ANG_W] ? ANG_W'(-((-diff) >>> 1)) : ANG_W'(diff >>> 1);
  assign half_abs = (half < 0) ? -half : half;

  assign den_sh  = REM_W'(den) <<< dstep;
  assign rem_ge  = (rem >= den_sh);
  assign quo_fin = rem_ge ? (quo | (QBITS'(1) << dstep)) : quo;
  assign quo_cl  = (quo_fin > A_MAX) ? A_MAX : quo_fin;
  assign a_div   = (half < 0) ? -A_W'({1'b0, quo_cl}) : A_W'({1'b0, quo_cl});

  assign div_skip = (den <= 0) || (num < 0) || (REM_W'(num) >= (REM_W'(den) <<< QBITS));
  assign sc_go    = (state == B_QSEL) || (state == B_S0 && sc_done && half != 0)
                    || (state == B_DCHK && div_skip) || (state == B_DIV && dstep == '0);

  always_comb begin
    unique case (state)
      B_M0:    mul_b = ys[0];
      B_M1:    mul_b = xs[0];
      B_M2:    mul_b = ys[3];
      default: mul_b = xs[3];
    endcase
  end
  assign prod   = PROD_W'(a) * PROD_W'(mul_b);
  assign prod_r = UNIT_W'((prod + MUL_RND) >>> 16);

  assign dx = 17'(arc.x1) - 17'(arc.x0);
  assign dy = 17'(arc.y1) - 17'(arc.y0);
  assign nx = 21'(xs[idx]) + UNIT_OFS;
  assign ny = 21'(ys[idx]) + UNIT_OFS;

  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign out_free = !out_valid || !out_stall;
  assign emit     = (state == B_EOUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      sc_start  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sc_start <= sc_go;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            arc   <= q_data;
            first <= 1'b1;
            parts <= '0;
            qe    <= '0;
            state <= B_QSEL;
          end
        end
        B_QSEL: begin
          qe       <= qe_fin;
          half     <= half_n;
          last     <= end_now;
          parts    <= parts_n;
          sc_angle <= qs_n;
          state    <= B_S0;
        end
        B_S0: begin
          if (sc_done) begin
            xs[0] <= q30_to_q16(sc_cos);
            ys[0] <= q30_to_q16(sc_sin);
            if (half == 0) begin
              xs[1] <= q30_to_q16(sc_cos);
              xs[2] <= q30_to_q16(sc_cos);
              xs[3] <= q30_to_q16(sc_cos);
              ys[1] <= q30_to_q16(sc_sin);
              ys[2] <= q30_to_q16(sc_sin);
              ys[3] <= q30_to_q16(sc_sin);
              idx   <= first ? 2'd0 : 2'd1;
              state <= B_EMUL;
            end else begin
              sc_angle <= half_abs;
              state    <= B_SH;
            end
          end
        end
        B_SH: begin
          if (sc_done) begin
            num   <= (NUM_W'(ONE_Q30) - NUM_W'(sc_cos)) <<< 18;
            den   <= DEN_W'(DEN_W'(sc_sin) * 3);
            state <= B_DCHK;
          end
        end
        B_DCHK: begin
          if (den <= 0 || num < 0) begin
            a        <= '0;
            sc_angle <= qe;
            state    <= B_S3;
          end else if (REM_W'(num) >= (REM_W'(den) <<< QBITS)) begin
            a        <= (half < 0) ? -A_W'({1'b0, A_MAX}) : A_W'({1'b0, A_MAX});
            sc_angle <= qe;
            state    <= B_S3;
          end else begin
            rem   <= REM_W'(num);
            quo   <= '0;
            dstep <= DSTEP_TOP;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (rem_ge) rem <= rem - den_sh;
          quo <= quo_fin;
          if (dstep == '0) begin
            a        <= a_div;
            sc_angle <= qe;
            state    <= B_S3;
          end else begin
            dstep <= dstep - 1'b1;
          end
        end
        B_S3: begin
          if (sc_done) begin
            xs[3] <= q30_to_q16(sc_cos);
            ys[3] <= q30_to_q16(sc_sin);
            state <= B_M0;
          end
        end
        B_M0: begin
          xs[1] <= xs[0] - prod_r;
          state <= B_M1;
        end
        B_M1: begin
          ys[1] <= ys[0] + prod_r;
          state <= B_M2;
        end
        B_M2: begin
          xs[2] <= xs[3] + prod_r;
          state <= B_M3;
        end
        B_M3: begin
          ys[2] <= ys[3] - prod_r;
          idx   <= first ? 2'd0 : 2'd1;
          state <= B_EMUL;
        end
        B_EMUL: begin
          px_raw <= (SC_W'(arc.x0) <<< 17) + SC_W'(SC_W'(dx) * SC_W'(nx)) + SC_RND;
          py_raw <= (SC_W'(arc.y0) <<< 17) + SC_W'(SC_W'(dy) * SC_W'(ny)) + SC_RND;
          state  <= B_EOUT;
        end
        B_EOUT: begin
          if (out_free) begin
            point_x    <= sat16(px_raw);
            point_y    <= sat16(py_raw);
            point_kind <= (idx != 2'd0);
            last_point <= last && (idx == 2'd3);
            if (idx == 2'd3) begin
              first <= 1'b0;
              state <= last ? B_IDLE : B_QSEL;
            end else begin
              idx   <= idx + 1'b1;
              state <= B_EMUL;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/elliptic_arc_to_bezier_top.sv @@
// Top level of the elliptic arc to cubic Bezier converter: configuration
// registers, front end, arc queue and back end. Depends on eab_pkg and all eab_ modules.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------
//  input    | in_valid / in_stall        | box_x1 box_y1 box_x2 box_y2 start_* end_*
//  output   | out_valid / out_stall      | point_x point_y point_kind last_point
//  config   | cfg_we                     | cfg_index cfg_data
//
// The front end takes a new arc only once it has queued the last; each arc needs two
// vectoring CORDIC runs and their scaling; a point at the box centre skips its run.
// The back end builds each quarter part with up to three rotation CORDIC runs and a
// 17-step divider, then emits its points; an arc has one to five parts.
// A two-entry queue lets the front end take the next arc while the back end works.
// Reset is synchronous; clockwise resets to 0 and compatible_mode to 1.
// A stalled output holds the back end; the front end keeps going until the queue fills.
`default_nettype none
module elliptic_arc_to_bezier_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  box_x1,
  input  logic signed [15:0]                  box_y1,
  input  logic signed [15:0]                  box_x2,
  input  logic signed [15:0]                  box_y2,
  input  logic signed [15:0]                  start_x,
  input  logic signed [15:0]                  start_y,
  input  logic signed [15:0]                  end_x,
  input  logic signed [15:0]                  end_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  point_x,
  output logic signed [15:0]                  point_y,
  output logic                                point_kind,
  output logic                                last_point,
  input  logic                                cfg_we,
  input  logic [eab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic                                cfg_data
);
  import eab_pkg::*;

  logic clockwise, compatible_mode;
  logic q_push, q_full, q_pop, q_empty;
  arc_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clockwise       <= 1'b0;
      compatible_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOCKWISE:  clockwise       <= cfg_data;
        REG_COMPATIBLE: compatible_mode <= cfg_data;
        default: ;
      endcase
    end
  end

  eab_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .box_x1          (box_x1),
    .box_y1          (box_y1),
    .box_x2          (box_x2),
    .box_y2          (box_y2),
    .start_x         (start_x),
    .start_y         (start_y),
    .end_x           (end_x),
    .end_y           (end_y),
    .clockwise       (clockwise),
    .compatible_mode (compatible_mode),
    .q_push          (q_push),
    .q_data          (q_wdata),
    .q_full          (q_full)
  );

  eab_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  eab_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_kind (point_kind),
    .last_point (last_point)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for elliptic_arc_to_bezier_top: directed and random arcs, all register settings,
// a bit-exact point predictor and a scoreboard of expected Bezier points.
// Depends on eab_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps
module tb_top;
  import eab_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 600;
  localparam longint Q_PI   = 205887;
  localparam longint Q_HALF = 102944;
  localparam longint Q_TWO  = 411775;
  localparam longint GAIN   = 652032874;
  localparam longint ONE30  = 1073741824;
  localparam longint ATAN_TAB [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               kind;
    logic               last;
  } point_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0, cfg_we = 0, cfg_data = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic signed [15:0] box_x1 = 0, box_y1 = 0, box_x2 = 0, box_y2 = 0;
  logic signed [15:0] start_x = 0, start_y = 0, end_x = 0, end_y = 0;
  logic in_stall, out_valid, point_kind, last_point;
  logic signed [15:0] point_x, point_y;

  point_t expected_points[$];
  bit     failed = 0;
  bit     quiet = 0;
  bit     dir_cw = 0;
  bit     pull_in = 1;
  int     idle_cycles = 0;
  int     stall_left = 0;
  int     arc_base = 0;

  always #5 clk = ~clk;

  elliptic_arc_to_bezier_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .box_x1(box_x1), .box_y1(box_y1), .box_x2(box_x2), .box_y2(box_y2),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_x(point_x), .point_y(point_y), .point_kind(point_kind), .last_point(last_point),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint vector_angle(longint y, longint x);
    longint z, m, t, ay;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? Q_PI : -Q_PI;
      x = -x;
      y = -y;
    end
    ay = (y < 0) ? -y : y;
    m = (x > ay) ? x : ay;
    while (m < 64'sd1099511627776) begin
      x *= 2; y *= 2; m *= 2;
    end
    for (int i = 0; i < 16; i++) begin
      t = x;
      if (y > 0) begin
        x += y >>> i; y -= t >>> i; z += ATAN_TAB[i];
      end else begin
        x -= y >>> i; y += t >>> i; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic void rotate_unit(longint a, output longint c, output longint s);
    longint x, y, t;
    bit neg;
    x = GAIN; y = 0; neg = 0;
    while (a > Q_PI) a -= Q_TWO;
    while (a < -Q_PI) a += Q_TWO;
    if (a > Q_HALF) begin
      a -= Q_PI; neg = 1;
    end else if (a < -Q_HALF) begin
      a += Q_PI; neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      t = x;
      if (a >= 0) begin
        x -= y >>> i; y += t >>> i; a -= ATAN_TAB[i];
      end else begin
        x += y >>> i; y -= t >>> i; a += ATAN_TAB[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic longint to_q16(longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic longint to_box(longint c0, longint d, longint n);
    longint v;
    v = (c0 * 131072 + d * (n + 65536) + 65536) >>> 17;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic void queue_point(longint px, longint py, bit kind);
    point_t p;
    if (expected_points.size() - arc_base >= 16) return;
    p.x = px[15:0]; p.y = py[15:0]; p.kind = kind; p.last = 0;
    expected_points.push_back(p);
  endfunction

  function automatic void predict_part(longint cx0, longint cx1, longint cy0, longint cy1,
                                       longint qs, longint qe, bit first);
    longint xs[4], ys[4];
    longint c, s, ch, sh, a, half, num, den;
    a = 0;
    rotate_unit(qs, c, s);
    xs[0] = to_q16(c); ys[0] = to_q16(s);
    half = (qe - qs) / 2;
    if (half != 0) begin
      rotate_unit(half < 0 ? -half : half, ch, sh);
      num = (ONE30 - ch) * 262144;
      den = 3 * sh;
      if (den > 0) begin
        a = num / den;
        if (a < 0) a = 0;
        if (a > 65536) a = 65536;
      end
      if (half < 0) a = -a;
      rotate_unit(qe, c, s);
      xs[3] = to_q16(c); ys[3] = to_q16(s);
      xs[1] = xs[0] - ((a * ys[0] + 32768) >>> 16);
      ys[1] = ys[0] + ((a * xs[0] + 32768) >>> 16);
      xs[2] = xs[3] + ((a * ys[3] + 32768) >>> 16);
      ys[2] = ys[3] - ((a * xs[3] + 32768) >>> 16);
    end else begin
      for (int i = 1; i < 4; i++) begin
        xs[i] = xs[0]; ys[i] = ys[0];
      end
    end
    for (int i = first ? 0 : 1; i < 4; i++)
      queue_point(to_box(cx0, cx1 - cx0, xs[i]), to_box(cy0, cy1 - cy0, ys[i]), i != 0);
  endfunction

  function automatic void predict_arc(longint bx1, longint by1, longint bx2, longint by2,
                                      longint sx, longint sy, longint ex, longint ey);
    longint cx0, cx1, cy0, cy1, w, h, as, ae, qs, qe, fq;
    int parts;
    bit first, done;
    if (bx1 == bx2 || by1 == by2) return;
    cx0 = (bx1 < bx2) ? bx1 : bx2; cx1 = (bx1 < bx2) ? bx2 : bx1;
    cy0 = (by1 < by2) ? by1 : by2; cy1 = (by1 < by2) ? by2 : by1;
    w = cx1 - cx0;
    h = cy1 - cy0;
    as = vector_angle((2 * (sy - cy0) - h) * w, (2 * (sx - cx0) - w) * h);
    ae = vector_angle((2 * (ey - cy0) - h) * w, (2 * (ex - cx0) - w) * h);
    if (dir_cw) begin
      if (ae <= as) ae += Q_TWO;
    end else begin
      if (ae >= as) ae -= Q_TWO;
    end
    if (pull_in) begin
      cx1--; cy1--;
    end
    arc_base = expected_points.size();
    first = 1; done = 0; parts = 0; qe = 0;
    while (!done) begin
      if (first) begin
        qs = as;
        fq = as / Q_HALF;
        if (dir_cw) begin
          if (as % Q_HALF != 0 && as < 0) fq--;
          qe = (fq + 1) * Q_HALF;
        end else begin
          if (as % Q_HALF != 0 && as > 0) fq++;
          qe = (fq - 1) * Q_HALF;
        end
      end else begin
        qs = qe;
        qe += dir_cw ? Q_HALF : -Q_HALF;
      end
      parts++;
      if ((dir_cw && ae < qe) || (!dir_cw && ae > qe) || parts >= MAX_PARTS) begin
        qe = ae;
        done = 1;
      end
      predict_part(cx0, cx1, cy0, cy1, qs, qe, first);
      first = 0;
    end
    if (expected_points.size() > arc_base)
      expected_points[expected_points.size() - 1].last = 1;
  endfunction

  always @(posedge clk) begin
    point_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d kind=%0b last=%0b",
                 $time, point_x, point_y, point_kind, last_point);
        failed = 1;
      end else begin
        e = expected_points.pop_front();
        if (point_x !== e.x) begin
          $display("%0t: point_x expected %0d actual %0d", $time, e.x, point_x);
          failed = 1;
        end
        if (point_y !== e.y) begin
          $display("%0t: point_y expected %0d actual %0d", $time, e.y, point_y);
          failed = 1;
        end
        if (point_kind !== e.kind) begin
          $display("%0t: point_kind expected %0b actual %0b", $time, e.kind, point_kind);
          failed = 1;
        end
        if (last_point !== e.last) begin
          $display("%0t: last_point expected %0b actual %0b", $time, e.last, last_point);
          failed = 1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (quiet || rst) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send_arc(logic signed [15:0] bx1, logic signed [15:0] by1,
                          logic signed [15:0] bx2, logic signed [15:0] by2,
                          logic signed [15:0] sx, logic signed [15:0] sy,
                          logic signed [15:0] ex, logic signed [15:0] ey);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end else
      @(negedge clk);
    box_x1 = bx1; box_y1 = by1; box_x2 = bx2; box_y2 = by2;
    start_x = sx; start_y = sy; end_x = ex; end_y = ey;
    in_valid = 1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_arc(bx1, by1, bx2, by2, sx, sy, ex, ey);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    wait (expected_points.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    drain();
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    if (idx == REG_CLOCKWISE) dir_cw = val;
    else if (idx == REG_COMPATIBLE) pull_in = val;
  endtask

  task automatic send_random_arc();
    logic signed [15:0] bx1, by1, bx2, by2, sx, sy, ex, ey;
    int mode;
    mode = $urandom_range(0, 9);
    bx1 = 16'($urandom); by1 = 16'($urandom); bx2 = 16'($urandom); by2 = 16'($urandom);
    sx = 16'($urandom); sy = 16'($urandom); ex = 16'($urandom); ey = 16'($urandom);
    if (mode < 6) begin
      bx1 = 16'($urandom_range(0, 2000) - 1000);
      by1 = 16'($urandom_range(0, 2000) - 1000);
      bx2 = bx1 + 16'($urandom_range(1, 400));
      by2 = by1 + 16'($urandom_range(1, 400));
      if ($urandom_range(0, 1)) {bx1, bx2} = {bx2, bx1};
      sx = bx1 + 16'($urandom_range(0, 600) - 300);
      sy = by1 + 16'($urandom_range(0, 600) - 300);
      ex = bx2 + 16'($urandom_range(0, 600) - 300);
      ey = by2 + 16'($urandom_range(0, 600) - 300);
    end else if (mode == 6) begin
      ex = sx; ey = sy;
    end else if (mode == 7) begin
      if ($urandom_range(0, 1)) bx2 = bx1;
      else by2 = by1;
    end
    send_arc(bx1, by1, bx2, by2, sx, sy, ex, ey);
  endtask

  task automatic test_directed();
    send_arc(0, 0, 100, 100, 200, 50, 50, 200);
    send_arc(100, 100, 0, 0, 50, 50, 0, 50);
    send_arc(5, 0, 5, 10, 1, 1, 2, 2);
    send_arc(0, 7, 10, 7, 1, 1, 2, 2);
    send_arc(-10, -10, 10, 10, 0, 0, 0, 0);
    send_arc(-10, -10, 10, 10, 20, 0, 20, 0);
    send_arc(-10, -10, 10, 10, 20, 0, 0, 20);
    send_arc(-10, -10, 10, 10, 0, -20, -20, 0);
    send_arc(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767);
    send_arc(32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767);
    send_arc(-32768, 0, 32767, 1, 0, 0, 1, 1);
    send_arc(0, 0, 1, 1, 0, 0, 1, 0);
    send_arc(0, 0, 3, 2, 3, 1, 3, 1);
    send_arc(-32768, -32768, -32767, -32767, 32767, 32767, -32768, 32767);
    send_arc(100, -50, 300, 50, 400, 0, 200, -100);
  endtask

  task automatic test_settings();
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_CLOCKWISE, k[0]);
      write_reg(REG_COMPATIBLE, k[1]);
      test_directed();
      repeat (32) send_random_arc();
    end
  endtask

  task automatic test_ignored_index();
    write_reg(CFG_IDX_W'(2), 1);
    write_reg(CFG_IDX_W'(3), 0);
    repeat (10) send_random_arc();
  endtask

  task automatic test_random_tail();
    write_reg(REG_CLOCKWISE, 1);
    write_reg(REG_COMPATIBLE, 1);
    repeat (30) send_random_arc();
    drain();
    quiet = 1;
    repeat (30) send_random_arc();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_settings();
    test_ignored_index();
    test_random_tail();
    drain();
    if (!failed)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/eab_pkg.sv
rtl/core/eab_sincos.sv
rtl/core/eab_front.sv
rtl/core/eab_queue.sv
rtl/core/eab_back.sv
rtl/core/elliptic_arc_to_bezier_top.sv
tb/sv/tb_top.sv
